### sv/cspb_pkg.sv
// Shared types and constants for the clipped sprite blitter.
// Depends on nothing; every file of the block but the channel interfaces refers to it by scoped names.
package cspb_pkg;

  // Fixed field widths.
  localparam int COORD_W    = 11;
  localparam int DEST_W     = 20;
  localparam int ADDR_IN_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  // The sheet offset frame*frame_width + row*sheet_width + col stays below 2**14.
  localparam int SUM_W      = 14;

  // Item commands.
  localparam logic [1:0] CMD_DRAW     = 2'd0;
  localparam logic [1:0] CMD_PAL_WR   = 2'd1;
  localparam logic [1:0] CMD_SHEET_WR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_VALID = 3'd5;

  // Configuration register file contents.
  typedef struct packed {
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [6:0]  sheet_width;
    logic [6:0]  frame_width;
    logic [6:0]  sprite_height;
    logic        palette_valid;
  } cfg_t;

  // Per-item control flags carried down the pipeline.
  typedef struct packed {
    logic vis;       // draw item whose pixel is inside frame and screen, palette valid
    logic pal_wr;    // palette write item
    logic sheet_wr;  // sheet write item
  } op_t;

  // Final stage contents handed from the lookup unit to the top level.
  typedef struct packed {
    logic              vis;
    logic              idx_ok;  // sheet byte indexes an existing palette entry
    logic [DEST_W-1:0] dest;
    logic [7:0]        pal;
  } look_t;

endpackage

### sv/cspb_intf.sv
// Channel interfaces of the clipped sprite blitter: draw/write items, results, config.
// Depends on nothing but plain logic types.
interface cspb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [5:0]        frame_number;
  logic [5:0]        col;
  logic [5:0]        row;
  logic [11:0]       mem_address;
  logic [7:0]        mem_data;

  modport source (output valid, command, pos_x, pos_y, frame_number, col, row,
                  mem_address, mem_data, input ready);
  modport sink (input valid, command, pos_x, pos_y, frame_number, col, row,
                mem_address, mem_data, output ready);
endinterface

interface cspb_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [19:0] dest_address;
  logic [7:0]  color;

  modport source (output valid, write_enable, dest_address, color, input ready);
  modport sink (input valid, write_enable, dest_address, color, output ready);
endinterface

interface cspb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/cspb_addr_gen.sv
// Address stages of the blitter: clipping, sheet offset with wrap, screen address.
// Depends on cspb_pkg for widths, command codes, cfg_t and op_t.
module cspb_addr_gen #(
  parameter int SHEET_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              take,
  input  cspb_pkg::cfg_t                    cfg,
  input  logic [1:0]                        command,
  input  logic signed [10:0]                pos_x,
  input  logic signed [10:0]                pos_y,
  input  logic [5:0]                        frame_number,
  input  logic [5:0]                        col,
  input  logic [5:0]                        row,
  input  logic [11:0]                       mem_address,
  input  logic [7:0]                        mem_data,
  output logic                              s3_valid,
  output cspb_pkg::op_t                     s3_op,
  output logic [$clog2(SHEET_BYTES)-1:0]    s3_saddr,
  output logic [cspb_pkg::DEST_W-1:0]       s3_dest,
  output logic [11:0]                       s3_maddr,
  output logic [7:0]                        s3_mdata
);

  localparam int AW    = $clog2(SHEET_BYTES);
  localparam int SW    = cspb_pkg::SUM_W;
  localparam int PW2   = 2 * SW + 1;
  // Reciprocal of the sheet size, scaled by 2**SUM_W; the quotient estimate is low by
  // at most one, so a single compare and subtract finishes the wrap.
  localparam logic [SW:0] RECIP = (SW + 1)'((1 << SW) / SHEET_BYTES);

  // Stage 1 input logic: screen point, clipping tests and sheet offset.
  logic signed [11:0] x_s, y_s;
  logic               x_on, y_on, vis_c;
  logic [SW-1:0]      sum_c;

  always_comb begin
    x_s   = $signed({pos_x[10], pos_x}) + $signed({6'b0, col});
    y_s   = $signed({pos_y[10], pos_y}) + $signed({6'b0, row});
    x_on  = !x_s[11] && (x_s[10:0] < cfg.screen_width);
    y_on  = !y_s[11] && (y_s[10:0] < cfg.screen_height);
    vis_c = (command == cspb_pkg::CMD_DRAW) && cfg.palette_valid
            && ({1'b0, col} < cfg.frame_width) && ({1'b0, row} < cfg.sprite_height)
            && x_on && y_on;
    sum_c = SW'(frame_number) * SW'(cfg.frame_width)
          + SW'(row) * SW'(cfg.sheet_width) + SW'(col);
  end

  // Stage 1 registers.
  logic            s1_valid_r;
  cspb_pkg::op_t   s1_op_r;
  logic [SW-1:0]   s1_sum_r;
  logic [10:0]     s1_x_r, s1_y_r;
  logic [11:0]     s1_maddr_r;
  logic [7:0]      s1_mdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r.vis      <= vis_c;
      s1_op_r.pal_wr   <= (command == cspb_pkg::CMD_PAL_WR);
      s1_op_r.sheet_wr <= (command == cspb_pkg::CMD_SHEET_WR);
      s1_sum_r         <= sum_c;
      s1_x_r           <= x_s[10:0];
      s1_y_r           <= y_s[10:0];
      s1_maddr_r       <= mem_address;
      s1_mdata_r       <= mem_data;
    end
  end

  // Stage 2: quotient estimate and row offset on the screen.
  logic [PW2-1:0] qprod;
  logic [21:0]    yw_c;

  assign qprod = PW2'(s1_sum_r) * PW2'(RECIP);
  assign yw_c  = 22'(s1_y_r) * 22'(cfg.screen_width);

  logic            s2_valid_r;
  cspb_pkg::op_t   s2_op_r;
  logic [SW-1:0]   s2_sum_r;
  logic [SW:0]     s2_q_r;
  logic [21:0]     s2_yw_r;
  logic [10:0]     s2_x_r;
  logic [11:0]     s2_maddr_r;
  logic [7:0]      s2_mdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r    <= s1_op_r;
      s2_sum_r   <= s1_sum_r;
      s2_q_r     <= qprod[PW2-1:SW];
      s2_yw_r    <= yw_c;
      s2_x_r     <= s1_x_r;
      s2_maddr_r <= s1_maddr_r;
      s2_mdata_r <= s1_mdata_r;
    end
  end

  // Stage 3: remainder with one correction step, and the linear screen address.
  logic [31:0]   qsb;
  logic [SW-1:0] rem0, rem1;

  always_comb begin
    qsb  = 32'(s2_q_r) * 32'(SHEET_BYTES);
    rem0 = s2_sum_r - SW'(qsb);
    rem1 = (32'(rem0) >= 32'(SHEET_BYTES)) ? rem0 - SW'(SHEET_BYTES) : rem0;
  end

  logic                          s3_valid_r;
  cspb_pkg::op_t                 s3_op_r;
  logic [AW-1:0]                 s3_saddr_r;
  logic [cspb_pkg::DEST_W-1:0]   s3_dest_r;
  logic [11:0]                   s3_maddr_r;
  logic [7:0]                    s3_mdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op_r    <= s2_op_r;
      s3_saddr_r <= AW'(rem1);
      s3_dest_r  <= cspb_pkg::DEST_W'(22'(s2_x_r) + s2_yw_r);
      s3_maddr_r <= s2_maddr_r;
      s3_mdata_r <= s2_mdata_r;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_op    = s3_op_r;
  assign s3_saddr = s3_saddr_r;
  assign s3_dest  = s3_dest_r;
  assign s3_maddr = s3_maddr_r;
  assign s3_mdata = s3_mdata_r;

endmodule

### sv/cspb_lookup.sv
// Memory stages of the blitter: sheet store, palette store and the clearing sweep.
// Depends on cspb_pkg for op_t, look_t and widths.
module cspb_lookup #(
  parameter int SHEET_BYTES     = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              s3_valid,
  input  cspb_pkg::op_t                     s3_op,
  input  logic [$clog2(SHEET_BYTES)-1:0]    s3_saddr,
  input  logic [cspb_pkg::DEST_W-1:0]       s3_dest,
  input  logic [11:0]                       s3_maddr,
  input  logic [7:0]                        s3_mdata,
  output logic                              clr_busy,
  output logic                              s5_valid,
  output cspb_pkg::look_t                   s5
);

  localparam int AW    = $clog2(SHEET_BYTES);
  localparam int PW    = $clog2(PALETTE_ENTRIES);
  // The sweep covers the larger of the two stores.
  localparam int CLR_N = (SHEET_BYTES > PALETTE_ENTRIES) ? SHEET_BYTES : PALETTE_ENTRIES;
  localparam int CW    = $clog2(CLR_N);

  // Clearing sweep after reset: one entry of each store per cycle, both side by side.
  logic          clr_busy_r;
  logic [CW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == CW'(CLR_N - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign clr_busy = clr_busy_r;

  // Every item touches the sheet in this stage and the palette in the next one,
  // reads and writes alike, so program order is kept without forwarding.
  logic          sh_we;
  logic [AW-1:0] sh_wa;
  logic [7:0]    sh_wd;

  always_comb begin
    sh_we = (clr_busy_r && (32'(clr_idx_r) < 32'(SHEET_BYTES)))
            || (adv && s3_valid && s3_op.sheet_wr && (32'(s3_maddr) < 32'(SHEET_BYTES)));
    sh_wa = clr_busy_r ? AW'(clr_idx_r) : AW'(s3_maddr);
    sh_wd = clr_busy_r ? 8'h00 : s3_mdata;
  end

  logic [7:0] sheet_mem [SHEET_BYTES];
  logic [7:0] s4_byte_r;

  always_ff @(posedge clk) begin
    if (sh_we) begin
      sheet_mem[sh_wa] <= sh_wd;
    end
    if (adv) begin
      s4_byte_r <= sheet_mem[s3_saddr];
    end
  end

  // Stage 4 registers beside the sheet read data.
  logic                        s4_valid_r;
  cspb_pkg::op_t               s4_op_r;
  logic [cspb_pkg::DEST_W-1:0] s4_dest_r;
  logic [11:0]                 s4_maddr_r;
  logic [7:0]                  s4_mdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_op_r    <= s3_op;
      s4_dest_r  <= s3_dest;
      s4_maddr_r <= s3_maddr;
      s4_mdata_r <= s3_mdata;
    end
  end

  // Palette write port: clearing sweep or a palette write item.
  logic          pl_we;
  logic [PW-1:0] pl_wa;
  logic [7:0]    pl_wd;

  always_comb begin
    pl_we = (clr_busy_r && (32'(clr_idx_r) < 32'(PALETTE_ENTRIES)))
            || (adv && s4_valid_r && s4_op_r.pal_wr
                && (32'(s4_maddr_r) < 32'(PALETTE_ENTRIES)));
    pl_wa = clr_busy_r ? PW'(clr_idx_r) : PW'(s4_maddr_r);
    pl_wd = clr_busy_r ? 8'h00 : s4_mdata_r;
  end

  logic [7:0] pal_mem [PALETTE_ENTRIES];
  logic [7:0] s5_pal_r;

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pal_mem[pl_wa] <= pl_wd;
    end
    if (adv) begin
      s5_pal_r <= pal_mem[PW'(s4_byte_r)];
    end
  end

  // Stage 5 registers.
  logic                        s5_valid_r;
  logic                        s5_vis_r;
  logic                        s5_idx_ok_r;
  logic [cspb_pkg::DEST_W-1:0] s5_dest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_vis_r    <= s4_op_r.vis;
      s5_idx_ok_r <= (32'(s4_byte_r) < 32'(PALETTE_ENTRIES));
      s5_dest_r   <= s4_dest_r;
    end
  end

  assign s5_valid   = s5_valid_r;
  assign s5.vis     = s5_vis_r;
  assign s5.idx_ok  = s5_idx_ok_r;
  assign s5.dest    = s5_dest_r;
  assign s5.pal     = s5_pal_r;

endmodule

### sv/clipped_sprite_blitter.sv
// Top level of the clipped sprite blitter: config registers, pipeline control, result.
// Depends on cspb_pkg, the channel interfaces, cspb_addr_gen and cspb_lookup.
//
//   channel   port     direction  carries
//   input     in_ch    sink       command, pos_x, pos_y, frame_number, col, row,
//                                 mem_address, mem_data
//   result    out_ch   source     write_enable, dest_address, color
//   config    cfg_ch   sink       index, data
//
// One item is accepted per cycle while the pipeline advances; its result is offered
// from the last stage register, one result per item, in order. The five stages are
// the address stages (offset, wrap, screen address), the sheet read and the palette read.
// After reset a clearing sweep zeroes both stores, walking every index below the larger
// of SHEET_BYTES and PALETTE_ENTRIES; no item is accepted until it ends, while config
// writes are taken at once.
// A held result stalls the whole pipeline; the input keeps taking items while the
// result register is empty or being drained in the same cycle.
module clipped_sprite_blitter #(
  parameter int SHEET_BYTES     = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  cspb_in_if.sink     in_ch,
  cspb_out_if.source  out_ch,
  cspb_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(SHEET_BYTES);

  // Configuration registers; writes are always taken.
  cspb_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 11'd256;
      cfg_r.screen_height <= 11'd212;
      cfg_r.sheet_width   <= 7'd64;
      cfg_r.frame_width   <= 7'd16;
      cfg_r.sprite_height <= 7'd16;
      cfg_r.palette_valid <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cspb_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_ch.data;
        cspb_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_ch.data;
        cspb_pkg::REG_SHEET_WIDTH:   cfg_r.sheet_width   <= cfg_ch.data[6:0];
        cspb_pkg::REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_ch.data[6:0];
        cspb_pkg::REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_ch.data[6:0];
        cspb_pkg::REG_PALETTE_VALID: cfg_r.palette_valid <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the whole pipe moves when the result register can be refilled.
  logic adv, take, clr_busy, s5_valid;

  assign adv         = !s5_valid || out_ch.ready;
  assign in_ch.ready = adv && !clr_busy;
  assign take        = in_ch.valid && in_ch.ready;

  cspb_pkg::op_t                 s3_op;
  logic                          s3_valid;
  logic [AW-1:0]                 s3_saddr;
  logic [cspb_pkg::DEST_W-1:0]   s3_dest;
  logic [11:0]                   s3_maddr;
  logic [7:0]                    s3_mdata;
  cspb_pkg::look_t               s5;

  cspb_addr_gen #(
    .SHEET_BYTES (SHEET_BYTES)
  ) u_addr_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .take         (take),
    .cfg          (cfg_r),
    .command      (in_ch.command),
    .pos_x        (in_ch.pos_x),
    .pos_y        (in_ch.pos_y),
    .frame_number (in_ch.frame_number),
    .col          (in_ch.col),
    .row          (in_ch.row),
    .mem_address  (in_ch.mem_address),
    .mem_data     (in_ch.mem_data),
    .s3_valid     (s3_valid),
    .s3_op        (s3_op),
    .s3_saddr     (s3_saddr),
    .s3_dest      (s3_dest),
    .s3_maddr     (s3_maddr),
    .s3_mdata     (s3_mdata)
  );

  cspb_lookup #(
    .SHEET_BYTES     (SHEET_BYTES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s3_valid (s3_valid),
    .s3_op    (s3_op),
    .s3_saddr (s3_saddr),
    .s3_dest  (s3_dest),
    .s3_maddr (s3_maddr),
    .s3_mdata (s3_mdata),
    .clr_busy (clr_busy),
    .s5_valid (s5_valid),
    .s5       (s5)
  );

  // Result: a pixel is written only for a visible item whose in-range sheet byte gives a non-transparent palette value.
  logic we;

  assign we                  = s5.vis && s5.idx_ok && (s5.pal != 8'h00);
  assign out_ch.valid        = s5_valid;
  assign out_ch.write_enable = we;
  assign out_ch.dest_address = we ? s5.dest : '0;
  assign out_ch.color        = we ? s5.pal : 8'h00;

`ifndef NO_ASSERTIONS
  // No item may enter while the stores are being cleared.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("item accepted during clearing sweep");

  // The pipeline is empty when the clearing sweep ends.
  a_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy) |-> !out_ch.valid)
    else $error("result present at end of clearing sweep");

  // A written pixel never carries the transparent color.
  a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.write_enable) |-> (out_ch.color != 8'h00))
    else $error("pixel written with transparent color");

  // A result without a write carries zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.write_enable)
      |-> (out_ch.dest_address == '0 && out_ch.color == 8'h00))
    else $error("nonzero fields on a result without a write");
`endif

endmodule
